@@ rtl/jses_pkg.sv @@
// shared types, constants and helper functions for the json string escaper
`default_nettype none

package jses_pkg;

	localparam int BODY_MAX = 6;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [7:0] REP_B0      = 8'hef;
	localparam logic [7:0] REP_B1      = 8'hbf;
	localparam logic [7:0] REP_B2      = 8'hbd;
	localparam logic [7:0] BSLASH      = 8'h5c;
	localparam logic [7:0] QUOTE       = 8'h22;
	localparam logic [7:0] CODE_BS     = 8'h08;
	localparam logic [7:0] CODE_FF     = 8'h0c;
	localparam logic [7:0] CODE_LF     = 8'h0a;
	localparam logic [7:0] CODE_CR     = 8'h0d;
	localparam logic [7:0] CODE_TAB    = 8'h09;
	localparam logic [7:0] CH_B        = 8'h62;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_N        = 8'h6e;
	localparam logic [7:0] CH_R        = 8'h72;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_U        = 8'h75;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] HEX_ALPHA   = 8'h57;
	localparam logic [7:0] CTRL_LIMIT  = 8'h20;
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CONT_MIN    = 8'h80;
	localparam logic [7:0] CONT_MAX    = 8'hbf;

	// one queued work packet: replacement chars first, then the literal body
	typedef struct packed {
		logic [2:0]                rep_cnt;
		logic [BODY_MAX-1:0][7:0]  body;
		logic [2:0]                body_len;
		logic                      last;
	} desc_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] next_min;
		logic [7:0] next_max;
		logic [2:0] len;
	} rule_t;

	typedef struct packed {
		logic [BODY_MAX-1:0][7:0] body;
		logic [2:0]               len;
	} body_t;

	function automatic rule_t rule_of(input logic [7:0] lead);
		rule_t r;
		r = '0;
		if (lead >= 8'hc2 && lead <= 8'hdf) begin
			r = '{1'b1, 8'h80, 8'hbf, 3'd2};
		end else if (lead == 8'he0) begin
			r = '{1'b1, 8'ha0, 8'hbf, 3'd3};
		end else if (lead >= 8'he1 && lead <= 8'hec) begin
			r = '{1'b1, 8'h80, 8'hbf, 3'd3};
		end else if (lead == 8'hed) begin
			r = '{1'b1, 8'h80, 8'h9f, 3'd3};
		end else if (lead >= 8'hee && lead <= 8'hef) begin
			r = '{1'b1, 8'h80, 8'hbf, 3'd3};
		end else if (lead == 8'hf0) begin
			r = '{1'b1, 8'h90, 8'hbf, 3'd4};
		end else if (lead >= 8'hf1 && lead <= 8'hf3) begin
			r = '{1'b1, 8'h80, 8'hbf, 3'd4};
		end else if (lead == 8'hf4) begin
			r = '{1'b1, 8'h80, 8'h8f, 3'd4};
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (CH_ZERO + {4'b0, n}) : (HEX_ALPHA + {4'b0, n});
	endfunction

	// escaped form of a byte below 0x80, or the byte itself if it needs no escape
	function automatic body_t ascii_body(input logic [7:0] b);
		body_t r;
		r         = '0;
		r.body[0] = BSLASH;
		r.len     = 3'd2;
		case (b)
			QUOTE, BSLASH: r.body[1] = b;
			CODE_BS:       r.body[1] = CH_B;
			CODE_FF:       r.body[1] = CH_F;
			CODE_LF:       r.body[1] = CH_N;
			CODE_CR:       r.body[1] = CH_R;
			CODE_TAB:      r.body[1] = CH_T;
			default: begin
				if (b < CTRL_LIMIT) begin
					r.body[1] = CH_U;
					r.body[2] = CH_ZERO;
					r.body[3] = CH_ZERO;
					r.body[4] = hex_char(b[7:4]);
					r.body[5] = hex_char(b[3:0]);
					r.len     = 3'd6;
				end else begin
					r.body[0] = b;
					r.len     = 3'd1;
				end
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/json_string_escape_utf8_sanitize_core.sv @@
// top level of the json string escaper with utf-8 sanitizing
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------
//  input    | push / full      | in_byte, is_last
//  result   | empty / pop      | out_byte, last_out
//
// one input byte is taken per cycle while the packet queue has room; the
// front classifies it in that same cycle and queues at most one packet.
// the back emits one output byte per cycle while the reader keeps popping; an
// item yields 0 to 15 output bytes (a held byte none, an escape 2 to 6).
// results pass through the output register once their packet is at the queue head.
// reset clears held utf-8 state, the queue and the output register.
`default_nettype none

module json_string_escape_utf8_sanitize_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       is_last,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            last_out
);
	import jses_pkg::*;

	desc_t wr_desc, head;
	logic  wr_en, q_full, q_empty, q_rd, accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	jses_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.desc       (wr_desc),
		.desc_valid (wr_en)
	);

	jses_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_desc),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (head),
		.empty   (q_empty)
	);

	jses_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (q_empty),
		.head_pop   (q_rd),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_out   (last_out)
	);

	// the back never retires a packet that is not there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("packet queue read while empty");

	// a queued packet never exceeds fifteen output bytes
	a_packet_size: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_desc.rep_cnt <= 3'd4 && wr_desc.body_len <= 3'd6 &&
		           ({3'b0, wr_desc.rep_cnt} * 6'd3 + {3'b0, wr_desc.body_len}) <= 6'd15))
		else $error("oversized packet");

	// a string end always yields at least one output byte
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_last) |-> wr_en)
		else $error("string end produced no packet");

	// a packet written into a full queue would be lost
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full)
		else $error("packet queue write while full");

endmodule

`default_nettype wire

@@ rtl/jses_front.sv @@
// front end: utf-8 sequence tracking and classification of each input byte
`default_nettype none

module jses_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      in_byte,
	input  wire logic            is_last,
	output jses_pkg::desc_t      desc,
	output logic                 desc_valid
);
	import jses_pkg::*;

	logic [2:0][7:0] held_q, held_d;
	logic [1:0]      held_cnt_q, held_cnt_d;
	logic [2:0]      seq_len_q, seq_len_d;

	rule_t      fr, hr;
	body_t      ab;
	logic       ok, do_fresh, complete;
	logic [2:0] pre_rep, fresh_rep, post_rep;

	assign fr = rule_of(in_byte);
	assign hr = rule_of(held_q[0]);
	assign ab = ascii_body(in_byte);

	always_comb begin
		if (held_cnt_q == 2'd1) begin
			ok = hr.valid && in_byte >= hr.next_min && in_byte <= hr.next_max;
		end else begin
			ok = in_byte >= CONT_MIN && in_byte <= CONT_MAX;
		end
		do_fresh = (held_cnt_q == 2'd0) || !ok;
		complete = !do_fresh && (({1'b0, held_cnt_q} + 3'd1) >= seq_len_q);

		desc.body     = '0;
		desc.body_len = 3'd0;
		pre_rep       = 3'd0;
		fresh_rep     = 3'd0;
		held_d        = held_q;
		held_cnt_d    = held_cnt_q;
		seq_len_d     = seq_len_q;

		if (do_fresh) begin
			// held bytes that the new byte breaks each become a replacement
			pre_rep    = {1'b0, held_cnt_q};
			held_cnt_d = 2'd0;
			seq_len_d  = 3'd0;
			if (in_byte < ASCII_LIMIT) begin
				desc.body     = ab.body;
				desc.body_len = ab.len;
			end else if (fr.valid) begin
				held_d[0]  = in_byte;
				held_cnt_d = 2'd1;
				seq_len_d  = fr.len;
			end else begin
				fresh_rep = 3'd1;
			end
		end else if (complete) begin
			desc.body[0] = held_q[0];
			desc.body[1] = (held_cnt_q >= 2'd2) ? held_q[1] : in_byte;
			desc.body[2] = (held_cnt_q == 2'd3) ? held_q[2] :
			               ((held_cnt_q == 2'd2) ? in_byte : 8'h00);
			desc.body[3] = (held_cnt_q == 2'd3) ? in_byte : 8'h00;
			desc.body_len = {1'b0, held_cnt_q} + 3'd1;
			held_cnt_d    = 2'd0;
			seq_len_d     = 3'd0;
		end else begin
			held_d[held_cnt_q] = in_byte;
			held_cnt_d         = held_cnt_q + 2'd1;
		end

		// cut-off sequence at end of string
		post_rep = is_last ? {1'b0, held_cnt_d} : 3'd0;
		if (is_last) begin
			held_cnt_d = 2'd0;
			seq_len_d  = 3'd0;
		end

		desc.rep_cnt = pre_rep + fresh_rep + post_rep;
		desc.last    = is_last;
		desc_valid   = accept && (desc.rep_cnt != 3'd0 || desc.body_len != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= 2'd0;
			seq_len_q  <= 3'd0;
		end else if (accept) begin
			held_q     <= held_d;
			held_cnt_q <= held_cnt_d;
			seq_len_q  <= seq_len_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/jses_fifo.sv @@
// small register queue of work packets between front and back
`default_nettype none

module jses_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire jses_pkg::desc_t wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output jses_pkg::desc_t      rd_data,
	output logic                 empty
);
	import jses_pkg::*;

	desc_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/jses_back.sv @@
// back end: turns packets into output bytes, one per cycle while the output register is free
`default_nettype none

module jses_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jses_pkg::desc_t head,
	input  wire logic            head_empty,
	output logic                 head_pop,
	output logic                 empty,
	input  wire logic            pop,
	output logic [7:0]           out_byte,
	output logic                 last_out
);
	import jses_pkg::*;

	logic [2:0] rep_idx_q;
	logic [1:0] sub_q;
	logic [2:0] body_idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       step, in_reps, final_byte;
	logic [7:0] cur_byte, rep_byte, body_byte;

	assign step    = !head_empty && (!out_valid_q || pop);
	assign in_reps = rep_idx_q < head.rep_cnt;

	always_comb begin
		case (sub_q)
			2'd0:    rep_byte = REP_B0;
			2'd1:    rep_byte = REP_B1;
			default: rep_byte = REP_B2;
		endcase
		case (body_idx_q)
			3'd0:    body_byte = head.body[0];
			3'd1:    body_byte = head.body[1];
			3'd2:    body_byte = head.body[2];
			3'd3:    body_byte = head.body[3];
			3'd4:    body_byte = head.body[4];
			3'd5:    body_byte = head.body[5];
			default: body_byte = 8'h00;
		endcase
		cur_byte = in_reps ? rep_byte : body_byte;
		if (in_reps) begin
			final_byte = (rep_idx_q == head.rep_cnt - 3'd1) && (sub_q == 2'd2) &&
			             (head.body_len == 3'd0);
		end else begin
			final_byte = (body_idx_q == head.body_len - 3'd1);
		end
	end

	assign head_pop = step && final_byte;
	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign last_out = out_last_q;

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= cur_byte;
			out_last_q <= final_byte && head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_idx_q   <= 3'd0;
			sub_q       <= 2'd0;
			body_idx_q  <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				if (final_byte) begin
					rep_idx_q  <= 3'd0;
					sub_q      <= 2'd0;
					body_idx_q <= 3'd0;
				end else if (in_reps) begin
					if (sub_q == 2'd2) begin
						sub_q     <= 2'd0;
						rep_idx_q <= rep_idx_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end else begin
					body_idx_q <= body_idx_q + 3'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire
